// ----- rtl/manchester_frame_edge_scheduler_macros.svh -----
// ----------------------------------------------------------------------------
// manchester_frame_edge_scheduler_macros.svh
// Assertion macros shared by the edge scheduler modules.
// ----------------------------------------------------------------------------
`ifndef MANCHESTER_FRAME_EDGE_SCHEDULER_MACROS_SVH
`define MANCHESTER_FRAME_EDGE_SCHEDULER_MACROS_SVH

`ifndef SYNTHESIS

// Property holds at every clock edge outside reset
`define MFES_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mfes assertion failed");

// Condition must never be true outside reset
`define MFES_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("mfes forbidden condition");

`else

`define MFES_ASSERT(lbl, clk, rst_n, prop)
`define MFES_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ----- rtl/mfes_pkg.sv -----
// ----------------------------------------------------------------------------
// mfes_pkg
// Types and constants of the Manchester frame edge scheduler.
// ----------------------------------------------------------------------------
package mfes_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_ETU      = 2'd0;
    localparam logic [1:0] REG_DLY_ZERO = 2'd1;
    localparam logic [1:0] REG_DLY_ONE  = 2'd2;

    // Reset values of the configuration registers
    localparam logic [15:0] ETU_RST      = 16'd128;
    localparam logic [15:0] DLY_ZERO_RST = 16'd1164;
    localparam logic [15:0] DLY_ONE_RST  = 16'd1228;

    // Largest data bit count of one byte
    localparam logic [3:0] MAX_BITS = 4'd8;

    // Output event kinds
    localparam logic KIND_TOGGLE = 1'b0;
    localparam logic KIND_STOP   = 1'b1;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DLY,
        S_PULSE,
        S_BIT,
        S_BIT2,
        S_END
    } t_state;

    // Which wait an emitted event carries
    typedef enum logic [1:0] {
        EV_DLY,
        EV_HALF,
        EV_ETU,
        EV_END
    } t_ev;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic emit;
        t_ev  ev;
        logic last;
        logic advance;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic start;
        logic fin;
        logic has_bits;
        logic bit_diff;
        logic more_bits;
        logic out_free;
    } t_dp_stat;

endpackage

// ----- rtl/manchester_frame_edge_scheduler.sv -----
// ----------------------------------------------------------------------------
// manchester_frame_edge_scheduler
// Turns frame bytes into timed toggle events for a Manchester transmitter.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) takes one byte transaction with its bit
//   count, parity and framing flags. Output channel (o_valid/i_ready) gives
//   one event per transaction: wait, timer restart flag, kind, last flag.
//   Configuration is written over the APB port (etu at 0x0, delay after a
//   zero bit at 0x4, delay after a one bit at 0x8) while the block is idle.
// Timing:
//   A byte is taken, passes the dispatch state, then its events leave one per
//   cycle through the output register while i_ready is high. A byte yields
//   up to 21 events (delay, start pulse, nine two-event bits, stop). The
//   sequencer handles one byte at a time; o_ready is high only when it is
//   idle, and a byte with no events returns it to idle from dispatch.
// Reset:
//   Synchronous, active low. Registers return to 128/1164/1228 and the
//   remembered line bit to one; no event is pending.
// Stall:
//   When i_ready is low, the pending event holds and the sequencer waits.
// ----------------------------------------------------------------------------
module manchester_frame_edge_scheduler
    import mfes_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic [3:0]  i_bit_count,
    input  logic        i_add_parity,
    input  logic        i_frame_start,
    input  logic        i_frame_end,
    input  logic        i_prior_last_bit,
    input  logic [15:0] i_elapsed_ticks,
    // output channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_wait_ticks,
    output logic        o_restart_count,
    output logic        o_event_kind,
    output logic        o_last_of_run,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] r_etu;
    logic [15:0] r_dly_zero;
    logic [15:0] r_dly_one;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;
    t_dp_cmd     cmd;
    t_dp_stat    stat;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_etu      <= ETU_RST;
            r_dly_zero <= DLY_ZERO_RST;
            r_dly_one  <= DLY_ONE_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_ETU:      r_etu      <= pwdata[15:0];
                REG_DLY_ZERO: r_dly_zero <= pwdata[15:0];
                REG_DLY_ONE:  r_dly_one  <= pwdata[15:0];
                default:      r_etu      <= r_etu;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (cfg_idx)
            REG_ETU:      prdata = {16'd0, r_etu};
            REG_DLY_ZERO: prdata = {16'd0, r_dly_zero};
            REG_DLY_ONE:  prdata = {16'd0, r_dly_one};
            default:      prdata = 32'd0;
        endcase
    end

    mfes_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    mfes_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_data_byte      (i_data_byte),
        .i_bit_count      (i_bit_count),
        .i_add_parity     (i_add_parity),
        .i_frame_start    (i_frame_start),
        .i_frame_end      (i_frame_end),
        .i_prior_last_bit (i_prior_last_bit),
        .i_elapsed_ticks  (i_elapsed_ticks),
        .i_etu            (r_etu),
        .i_dly_zero       (r_dly_zero),
        .i_dly_one        (r_dly_one),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_wait_ticks     (o_wait_ticks),
        .o_restart_count  (o_restart_count),
        .o_event_kind     (o_event_kind),
        .o_last_of_run    (o_last_of_run)
    );

endmodule

// ----- rtl/mfes_ctrl.sv -----
// ----------------------------------------------------------------------------
// mfes_ctrl
// Sequencer: walks one byte through delay, start pulse, bits and end event.
// ----------------------------------------------------------------------------
`include "manchester_frame_edge_scheduler_macros.svh"

module mfes_ctrl
    import mfes_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    t_state after_bit;

    // Where to go once the current bit is fully sent
    always_comb begin
        if (i_stat.more_bits) begin
            after_bit = S_BIT;
        end else if (i_stat.fin) begin
            after_bit = S_END;
        end else begin
            after_bit = S_IDLE;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (i_stat.start) begin
                    n_state = S_DLY;
                end else if (i_stat.has_bits) begin
                    n_state = S_BIT;
                end else if (i_stat.fin) begin
                    n_state = S_END;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DLY: begin
                if (i_stat.out_free) begin
                    n_state = S_PULSE;
                end
            end
            S_PULSE: begin
                if (i_stat.out_free) begin
                    if (i_stat.has_bits) begin
                        n_state = S_BIT;
                    end else if (i_stat.fin) begin
                        n_state = S_END;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_BIT: begin
                if (i_stat.out_free) begin
                    n_state = i_stat.bit_diff ? after_bit : S_BIT2;
                end
            end
            S_BIT2: begin
                if (i_stat.out_free) begin
                    n_state = after_bit;
                end
            end
            S_END: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd         = '0;
        o_cmd.ev      = EV_HALF;
        o_ready       = (r_state == S_IDLE);
        o_cmd.load    = (r_state == S_IDLE) && i_valid;
        case (r_state)
            S_DLY: begin
                o_cmd.emit = i_stat.out_free;
                o_cmd.ev   = EV_DLY;
            end
            S_PULSE: begin
                o_cmd.emit = i_stat.out_free;
                o_cmd.ev   = EV_HALF;
                o_cmd.last = !i_stat.has_bits && !i_stat.fin;
            end
            S_BIT: begin
                o_cmd.emit    = i_stat.out_free;
                o_cmd.ev      = i_stat.bit_diff ? EV_ETU : EV_HALF;
                o_cmd.last    = i_stat.bit_diff && !i_stat.more_bits && !i_stat.fin;
                o_cmd.advance = i_stat.out_free && i_stat.bit_diff;
            end
            S_BIT2: begin
                o_cmd.emit    = i_stat.out_free;
                o_cmd.ev      = EV_HALF;
                o_cmd.last    = !i_stat.more_bits && !i_stat.fin;
                o_cmd.advance = i_stat.out_free;
            end
            S_END: begin
                o_cmd.emit = i_stat.out_free;
                o_cmd.ev   = EV_END;
                o_cmd.last = 1'b1;
            end
            default: begin
                o_cmd.emit = 1'b0;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A transaction always leads to the dispatch state
    `MFES_ASSERT(a_load_dispatch, i_clk, i_rst_n, o_cmd.load |=> r_state == S_LOAD)
    // The final event of a byte returns the sequencer to idle
    `MFES_ASSERT(a_last_idle, i_clk, i_rst_n, (o_cmd.emit && o_cmd.last) |=> r_state == S_IDLE)
    // A non-final event keeps the sequencer busy
    `MFES_ASSERT(a_more_busy, i_clk, i_rst_n, (o_cmd.emit && !o_cmd.last) |=> r_state != S_IDLE)

endmodule

// ----- rtl/mfes_dp.sv -----
// ----------------------------------------------------------------------------
// mfes_dp
// Datapath: holds the byte, bit state and parity, forms event waits and
// keeps the output register.
// ----------------------------------------------------------------------------
`include "manchester_frame_edge_scheduler_macros.svh"

module mfes_dp
    import mfes_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    // item fields
    input  logic [7:0]  i_data_byte,
    input  logic [3:0]  i_bit_count,
    input  logic        i_add_parity,
    input  logic        i_frame_start,
    input  logic        i_frame_end,
    input  logic        i_prior_last_bit,
    input  logic [15:0] i_elapsed_ticks,
    // configuration
    input  logic [15:0] i_etu,
    input  logic [15:0] i_dly_zero,
    input  logic [15:0] i_dly_one,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_wait_ticks,
    output logic        o_restart_count,
    output logic        o_event_kind,
    output logic        o_last_of_run
);

    logic [7:0]  r_data;
    logic [3:0]  r_cnt;
    logic        r_par_pend;
    logic        r_par;
    logic        r_prev_bit;
    logic        r_start;
    logic        r_fin;
    logic        r_prior;
    logic [15:0] r_elapsed;

    logic        r_out_valid;
    logic [15:0] r_wait;
    logic        r_restart;
    logic        r_kind;
    logic        r_last;

    logic        cur_bit;
    logic        cur_is_data;
    logic [15:0] half;
    logic [15:0] delay;
    logic        early;
    logic [15:0] n_wait;
    logic        n_restart;
    logic        n_kind;

    // Current bit: data LSB while data bits remain, else odd parity
    assign cur_is_data = (r_cnt != 4'd0);
    assign cur_bit     = cur_is_data ? r_data[0] : ~r_par;
    assign half        = {1'b0, i_etu[15:1]};

    // Status toward the sequencer
    always_comb begin
        o_stat.start     = r_start;
        o_stat.fin       = r_fin;
        o_stat.has_bits  = cur_is_data || r_par_pend;
        o_stat.bit_diff  = (cur_bit != r_prev_bit);
        o_stat.more_bits = (r_cnt > 4'd1) || ((r_cnt == 4'd1) && r_par_pend);
        o_stat.out_free  = !r_out_valid || i_ready;
    end

    // Frame delay reduced by the elapsed count
    assign delay = r_prior ? i_dly_one : i_dly_zero;
    assign early = (r_elapsed < delay);

    // Wait value of the event being emitted
    always_comb begin
        n_wait    = half;
        n_restart = 1'b0;
        n_kind    = KIND_TOGGLE;
        case (i_cmd.ev)
            EV_DLY: begin
                n_wait    = early ? (delay - r_elapsed) : half;
                n_restart = !early;
            end
            EV_HALF: n_wait = half;
            EV_ETU:  n_wait = i_etu;
            EV_END: begin
                n_wait = half;
                n_kind = KIND_STOP;
            end
            default: n_wait = half;
        endcase
    end

    // Item and bit state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_bit <= 1'b1;
            r_cnt      <= 4'd0;
            r_par_pend <= 1'b0;
            r_start    <= 1'b0;
            r_fin      <= 1'b0;
        end else if (i_cmd.load) begin
            r_data     <= i_data_byte;
            r_cnt      <= (i_bit_count > MAX_BITS) ? MAX_BITS : i_bit_count;
            r_par_pend <= i_add_parity;
            r_par      <= 1'b0;
            r_start    <= i_frame_start;
            r_fin      <= i_frame_end;
            r_prior    <= i_prior_last_bit;
            r_elapsed  <= i_elapsed_ticks;
            if (i_frame_start) begin
                r_prev_bit <= 1'b1;
            end
        end else if (i_cmd.advance) begin
            r_prev_bit <= cur_bit;
            if (cur_is_data) begin
                r_data <= {1'b0, r_data[7:1]};
                r_cnt  <= r_cnt - 4'd1;
                r_par  <= r_par ^ r_data[0];
            end else begin
                r_par_pend <= 1'b0;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_wait    <= n_wait;
            r_restart <= n_restart;
            r_kind    <= n_kind;
            r_last    <= i_cmd.last;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_wait_ticks    = r_wait;
    assign o_restart_count = r_restart;
    assign o_event_kind    = r_kind;
    assign o_last_of_run   = r_last;

    // A frame start resets the line level memory to one
    `MFES_ASSERT(a_start_prev, i_clk, i_rst_n, (i_cmd.load && i_frame_start) |=> r_prev_bit)
    // Never overwrite a result that the receiver has not taken
    `MFES_NEVER(a_no_overwrite, i_clk, i_rst_n, i_cmd.emit && r_out_valid && !i_ready)
    // Only the frame delay event can restart the timer
    `MFES_ASSERT(a_restart_dly, i_clk, i_rst_n, (i_cmd.emit && i_cmd.ev != EV_DLY) |=> !r_restart)

endmodule
